### rtl/core/rdn_pkg.sv
package rdn_pkg;

  localparam int unsigned FULL_SCALE = 32767;
  localparam logic [14:0] DZ_RESET = 15'd7849;

  // Square root iterations: one result bit per stage.
  localparam int unsigned SQRT_STAGES = 16;

  // Divider: quotient bits, one developed per pipeline stage.
  localparam int unsigned QBITS = 16;

  // Queue depth between the front and back halves.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

  // One classified sample on its way from the front part to the back part.
  typedef struct packed {
    logic        dz;
    logic        den_zero;
    logic        x_neg;
    logic        y_neg;
    logic [15:0] x_abs;
    logic [15:0] y_abs;
    logic [29:0] num;
    logic [30:0] den;
  } front_item_t;

endpackage

### rtl/core/radial_deadzone_normalizer.sv
// Radial deadzone for one analog stick.
// Input channel: drive in_x_raw/in_y_raw with start high; the pair is taken
// at any edge where start is high and busy is low. busy is held low, so one
// pair per cycle.
// Result channel: out_valid strobes for one cycle with out_x_out, out_y_out
// and out_in_deadzone; the receiver cannot stall, results are never held.
// Between the accepting edge and the result strobe lie 21 register stages in
// the front part counting the accepting edge (abs, squares, sum, a 16-stage
// square root, classification and the products), one through the queue, and
// 19 in the back part (split multiplies, their sum, a 16-stage restoring
// divider and the output register). Throughput is one pair per clock.
// Configuration: cfg_we with cfg_deadzone writes the deadzone radius; write
// it only while no sample is in flight. Reset (rst_n low, synchronous)
// empties the pipeline and loads the deadzone with 7849.
module radial_deadzone_normalizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_x_raw,
  input  logic signed [15:0] in_y_raw,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_deadzone,
  output logic               out_valid,
  output logic signed [15:0] out_x_out,
  output logic signed [15:0] out_y_out,
  output logic               out_in_deadzone
);

  logic [14:0] deadzone_r;
  rdn_pkg::front_item_t f_item, q_item;
  logic f_valid, q_valid, q_take;

  // Deadzone register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= rdn_pkg::DZ_RESET;
    end else if (cfg_we) begin
      deadzone_r <= cfg_deadzone;
    end
  end

  assign busy = 1'b0;

  rdn_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
    .x_raw(in_x_raw), .y_raw(in_y_raw), .deadzone(deadzone_r),
    .item_valid(f_valid), .item(f_item)
  );

  rdn_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_item),
    .rd_en(q_take), .rd_valid(q_valid), .rd_data(q_item)
  );

  rdn_back u_back (
    .clk(clk), .rst_n(rst_n), .item_valid(q_valid), .item(q_item),
    .item_take(q_take), .out_valid(out_valid), .x_out(out_x_out),
    .y_out(out_y_out), .in_deadzone(out_in_deadzone)
  );

endmodule

### rtl/core/rdn_front.sv
module rdn_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [15:0]  x_raw,
  input  logic signed [15:0]  y_raw,
  input  logic [14:0]         deadzone,
  output logic                item_valid,
  output rdn_pkg::front_item_t item
);

  localparam int unsigned NS = rdn_pkg::SQRT_STAGES;

  // Stage 0: absolute values and signs.
  logic        v0_r;
  logic [15:0] xa0_r, ya0_r;
  logic        xn0_r, yn0_r;
  logic [32:0] sq0_r;
  logic [15:0] xa_nxt, ya_nxt;

  always_comb begin
    xa_nxt = x_raw[15] ? 16'(-x_raw) : 16'(x_raw);
    ya_nxt = y_raw[15] ? 16'(-y_raw) : 16'(y_raw);
  end

  logic [31:0] xsq_r, ysq_r;
  logic        v1_r;
  logic [15:0] xa1_r, ya1_r;
  logic        xn1_r, yn1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
    xa0_r <= xa_nxt;
    ya0_r <= ya_nxt;
    xn0_r <= x_raw[15];
    yn0_r <= y_raw[15];
  end

  // Stage 1: the two squares, one multiplier each.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    xsq_r <= xa0_r * xa0_r;
    ysq_r <= ya0_r * ya0_r;
    xa1_r <= xa0_r;
    ya1_r <= ya0_r;
    xn1_r <= xn0_r;
    yn1_r <= yn0_r;
  end

  // Stage 2: sum of squares.
  always_ff @(posedge clk) begin
    sq0_r <= {1'b0, xsq_r} + {1'b0, ysq_r};
  end

  logic        v2_r;
  logic [15:0] xa2_r, ya2_r;
  logic        xn2_r, yn2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    xa2_r <= xa1_r;
    ya2_r <= ya1_r;
    xn2_r <= xn1_r;
    yn2_r <= yn1_r;
  end

  // Restoring square root, one result bit per stage. The sum of squares
  // never exceeds 2^31, so the bit pairs start at bits 31:30.
  logic [NS:1]       sv_r;
  logic [33:0]       rem_r  [1:NS];
  logic [16:0]       root_r [1:NS];
  logic [32:0]       rad_r  [1:NS];
  logic [15:0]       sxa_r  [1:NS];
  logic [15:0]       sya_r  [1:NS];
  logic [NS:1]       sxn_r, syn_r;

  for (genvar s = 0; s < NS; s++) begin : g_sqrt
    logic        v_in, xn_in, yn_in;
    logic [33:0] rem_in;
    logic [16:0] root_in;
    logic [32:0] rad_in;
    logic [15:0] xa_in, ya_in;
    logic [33:0] trial;
    logic [33:0] rsh;
    if (s == 0) begin : g_head
      always_comb begin
        v_in    = v2_r;
        rem_in  = '0;
        root_in = '0;
        rad_in  = sq0_r;
        xa_in   = xa2_r;
        ya_in   = ya2_r;
        xn_in   = xn2_r;
        yn_in   = yn2_r;
      end
    end else begin : g_body
      always_comb begin
        v_in    = sv_r[s];
        rem_in  = rem_r[s];
        root_in = root_r[s];
        rad_in  = rad_r[s];
        xa_in   = sxa_r[s];
        ya_in   = sya_r[s];
        xn_in   = sxn_r[s];
        yn_in   = syn_r[s];
      end
    end
    always_comb begin
      rsh   = {rem_in[31:0], rad_in[31:30]};
      trial = rsh - {15'd0, root_in, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[s+1] <= 1'b0;
      end else begin
        sv_r[s+1] <= v_in;
      end
      if (!trial[33]) begin
        rem_r[s+1]  <= trial;
        root_r[s+1] <= {root_in[15:0], 1'b1};
      end else begin
        rem_r[s+1]  <= rsh;
        root_r[s+1] <= {root_in[15:0], 1'b0};
      end
      rad_r[s+1] <= {rad_in[30:0], 2'b00};
      sxa_r[s+1] <= xa_in;
      sya_r[s+1] <= ya_in;
      sxn_r[s+1] <= xn_in;
      syn_r[s+1] <= yn_in;
    end
  end

  // Classification: deadzone test, clamp, and the excess and span for the products.
  logic [16:0] mag;
  logic [14:0] m_cl;
  logic [14:0] excess;
  logic [14:0] span;
  logic        cv_r;
  logic        cdz_r, cdzero_r, cxn_r, cyn_r;
  logic [15:0] cxa_r, cya_r;
  logic [14:0] cexc_r, cspan_r;
  logic [16:0] cmag_r;

  always_comb begin
    mag    = root_r[NS];
    m_cl   = (mag > 17'(rdn_pkg::FULL_SCALE)) ? 15'h7FFF : mag[14:0];
    excess = m_cl - deadzone;
    span   = 15'h7FFF - deadzone;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= sv_r[NS];
    end
    cdz_r    <= (mag <= {2'b00, deadzone});
    cdzero_r <= (deadzone == 15'h7FFF);
    cxn_r    <= sxn_r[NS];
    cyn_r    <= syn_r[NS];
    cxa_r    <= sxa_r[NS];
    cya_r    <= sya_r[NS];
    cexc_r   <= excess;
    cspan_r  <= span;
    cmag_r   <= mag;
  end

  // Products: 32767*excess and span*mag, registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= cv_r;
    end
    item.dz       <= cdz_r;
    item.den_zero <= cdzero_r;
    item.x_neg    <= cxn_r;
    item.y_neg    <= cyn_r;
    item.x_abs    <= cxa_r;
    item.y_abs    <= cya_r;
    item.num      <= 30'(({15'd0, cexc_r} << 15) - {15'd0, cexc_r});
    item.den      <= 31'(cspan_r * cmag_r);
  end

endmodule

### rtl/core/rdn_fifo.sv
module rdn_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  rdn_pkg::front_item_t wr_data,
  input  logic                 rd_en,
  output logic                 rd_valid,
  output rdn_pkg::front_item_t rd_data
);

  localparam int unsigned AW = rdn_pkg::FIFO_AW;

  rdn_pkg::front_item_t mem_r [rdn_pkg::FIFO_DEPTH];
  logic [AW:0] wp_r, rp_r;

  // Short queue; entries are read at the read pointer only.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en && rd_valid) rp_r <= rp_r + 1'b1;
    end
  end

  assign rd_valid = (wp_r != rp_r);
  assign rd_data  = mem_r[rp_r[AW-1:0]];

endmodule

### rtl/core/rdn_back.sv
module rdn_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  rdn_pkg::front_item_t item,
  output logic                 item_take,
  output logic                 out_valid,
  output logic signed [15:0]   x_out,
  output logic signed [15:0]   y_out,
  output logic                 in_deadzone
);

  localparam int unsigned NQ = rdn_pkg::QBITS;

  // The back part always takes an item; its divider pipeline never stalls.
  assign item_take = item_valid;

  // Setup: two dividends, each (32767*excess)*|axis| < 2^46.
  logic        pv_r;
  logic        pdz_r, pdzero_r, pxn_r, pyn_r;
  logic [45:0] pxd_r, pyd_r;
  logic [30:0] pden_r;

  // Multiply 30x16 as two 15-bit halves for each axis.
  logic [45:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic        mv_r;
  logic        mdz_r, mdzero_r, mxn_r, myn_r;
  logic [30:0] mden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= item_valid;
    end
    xlo_r    <= 46'(item.num[14:0] * item.x_abs);
    xhi_r    <= 46'(item.num[29:15] * item.x_abs);
    ylo_r    <= 46'(item.num[14:0] * item.y_abs);
    yhi_r    <= 46'(item.num[29:15] * item.y_abs);
    mdz_r    <= item.dz;
    mdzero_r <= item.den_zero;
    mxn_r    <= item.x_neg;
    myn_r    <= item.y_neg;
    mden_r   <= item.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= mv_r;
    end
    pxd_r    <= xlo_r + (xhi_r << 15);
    pyd_r    <= ylo_r + (yhi_r << 15);
    pdz_r    <= mdz_r;
    pdzero_r <= mdzero_r;
    pxn_r    <= mxn_r;
    pyn_r    <= myn_r;
    pden_r   <= mden_r;
  end

  // Restoring division, one quotient bit per stage. The quotient is at most
  // 32767 for a valid sample, so 16 bits; bits above are saturated after.
  // The quotient fits in 16 bits exactly when the dividend shifted down by
  // 16 is below den; otherwise it saturates.
  logic [NQ:1]   dv_r;
  logic [46:0]   xr_r  [1:NQ];
  logic [46:0]   yr_r  [1:NQ];
  logic [15:0]   xq_r  [1:NQ];
  logic [15:0]   yq_r  [1:NQ];
  logic [30:0]   dd_r  [1:NQ];
  logic [NQ:1]   ddz_r, ddzero_r, dxn_r, dyn_r, xov_r, yov_r;

  for (genvar s = 0; s < NQ; s++) begin : g_div
    localparam int unsigned SH = NQ - 1 - s;
    logic        v_in, dz_in, dzero_in, xn_in, yn_in, xov_in, yov_in;
    logic [46:0] xr_in, yr_in;
    logic [15:0] xq_in, yq_in;
    logic [30:0] dd_in;
    logic [46:0] dsx, dsy;
    logic [46:0] tx, ty;
    if (s == 0) begin : g_head
      always_comb begin
        v_in     = pv_r;
        xr_in    = {1'b0, pxd_r};
        yr_in    = {1'b0, pyd_r};
        xq_in    = '0;
        yq_in    = '0;
        dd_in    = pden_r;
        dz_in    = pdz_r;
        dzero_in = pdzero_r;
        xn_in    = pxn_r;
        yn_in    = pyn_r;
        xov_in   = ({1'b0, pxd_r[45:16]} >= pden_r);
        yov_in   = ({1'b0, pyd_r[45:16]} >= pden_r);
      end
    end else begin : g_body
      always_comb begin
        v_in     = dv_r[s];
        xr_in    = xr_r[s];
        yr_in    = yr_r[s];
        xq_in    = xq_r[s];
        yq_in    = yq_r[s];
        dd_in    = dd_r[s];
        dz_in    = ddz_r[s];
        dzero_in = ddzero_r[s];
        xn_in    = dxn_r[s];
        yn_in    = dyn_r[s];
        xov_in   = xov_r[s];
        yov_in   = yov_r[s];
      end
    end
    always_comb begin
      dsx = {16'd0, dd_in} << SH;
      dsy = {16'd0, dd_in} << SH;
      tx  = xr_in - dsx;
      ty  = yr_in - dsy;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s+1] <= 1'b0;
      end else begin
        dv_r[s+1] <= v_in;
      end
      xr_r[s+1]     <= tx[46] ? xr_in : tx;
      yr_r[s+1]     <= ty[46] ? yr_in : ty;
      xq_r[s+1]     <= {xq_in[14:0], ~tx[46]};
      yq_r[s+1]     <= {yq_in[14:0], ~ty[46]};
      dd_r[s+1]     <= dd_in;
      ddz_r[s+1]    <= dz_in;
      ddzero_r[s+1] <= dzero_in;
      dxn_r[s+1]    <= xn_in;
      dyn_r[s+1]    <= yn_in;
      xov_r[s+1]    <= xov_in;
      yov_r[s+1]    <= yov_in;
    end
  end

  // Saturate, zero for a deadzone or zero span, apply sign, and register the result beat.
  logic [15:0] xs, ys;
  always_comb begin
    xs = (xov_r[NQ] || xq_r[NQ] > 16'h7FFF) ? 16'h7FFF : xq_r[NQ];
    ys = (yov_r[NQ] || yq_r[NQ] > 16'h7FFF) ? 16'h7FFF : yq_r[NQ];
    if (ddzero_r[NQ]) begin
      xs = '0;
      ys = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_r[NQ];
    end
    in_deadzone <= ddz_r[NQ];
    if (ddz_r[NQ]) begin
      x_out <= '0;
      y_out <= '0;
    end else begin
      x_out <= dxn_r[NQ] ? 16'(-xs) : xs;
      y_out <= dyn_r[NQ] ? 16'(-ys) : ys;
    end
  end

endmodule

### rtl/core/rdn_checker.sv
module rdn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_x_out,
  input logic signed [15:0] out_y_out,
  input logic               out_in_deadzone
);

  // A deadzone beat carries zero on both axes.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_deadzone |-> out_x_out == 16'sd0 && out_y_out == 16'sd0)
    else $error("deadzone beat with nonzero axis");

  // Outputs never reach the most negative code.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x_out != 16'sh8000 && out_y_out != 16'sh8000)
    else $error("axis out of range");

  // No result appears right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result during reset");

  // The block never refuses a sample.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("busy asserted");

endmodule

bind radial_deadzone_normalizer rdn_checker u_rdn_checker (.*);
